[hdl/gwsc_pkg.sv]
// Package for the greedy weighted set cover block.
// Field widths, command and register codes, default sizes.
// No dependencies.
`default_nettype none
package gwsc_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned MaskW     = 64;
  localparam int unsigned CostW     = 32;
  localparam int unsigned IdxOutW   = 6;
  localparam int unsigned TotalW    = 38;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned ChosenDepth = 64;
  localparam int unsigned ChosenCntW  = 7;

  localparam int unsigned MaxSetsDef      = 64;
  localparam int unsigned UniverseBitsDef = 64;

  localparam logic [ModeW-1:0] ModeClear = 2'd0;
  localparam logic [ModeW-1:0] ModeLoad  = 2'd1;
  localparam logic [ModeW-1:0] ModeRun   = 2'd2;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgMaxPaths = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgUniverse = 8'd1;

  localparam logic [CfgDataW-1:0] MaxPathsRst = 7'd64;
  localparam logic [CfgDataW-1:0] UniverseRst = 7'd64;

endpackage
`default_nettype wire

[hdl/gwsc_if.sv]
// Channel interfaces: command input, result output, register write.
// Depends on gwsc_pkg.
`default_nettype none
interface gwsc_in_if;
  import gwsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [MaskW-1:0] set_mask;
  logic [CostW-1:0] cost;
  modport source (output valid, mode, set_mask, cost, input ready);
  modport sink   (input valid, mode, set_mask, cost, output ready);
endinterface

interface gwsc_out_if;
  import gwsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [IdxOutW-1:0] set_index;
  logic [TotalW-1:0]  run_total;
  logic               status;
  logic               last;
  modport source (output valid, set_index, run_total, status, last, input ready);
  modport sink   (input valid, set_index, run_total, status, last, output ready);
endinterface

interface gwsc_cfg_if;
  import gwsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/greedy_weighted_set_cover.sv]
// Greedy weighted set cover: set store, selection sequencer, result queue.
// Depends on gwsc_pkg and the interfaces in gwsc_if.sv.
//
//  channel | dir | handshake     | carries
//  in_i    | in  | valid/ready   | mode, set_mask, cost
//  out_o   | out | valid/ready   | set_index, run_total, status, last
//  cfg_i   | in  | valid/ready   | index, data (always ready)
//
// Clear and load complete while idle. A run walks the set store, per round, through
// one shared read port and a three-stage popcount/cross-multiply pipe, then emits
// the results one at a time via S_ERD, S_ELOAD and S_OUT, waiting in S_OUT on stalls.
// rst_ni is asynchronous; stores hold no reset. in_i is held off from a run
// until its last result has been taken.
`default_nettype none
module greedy_weighted_set_cover #(
  parameter int unsigned MAX_SETS      = gwsc_pkg::MaxSetsDef,
  parameter int unsigned UNIVERSE_BITS = gwsc_pkg::UniverseBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gwsc_in_if.sink     in_i,
  gwsc_out_if.source  out_o,
  gwsc_cfg_if.sink    cfg_i
);
  import gwsc_pkg::*;

  localparam int unsigned IW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned CW = $clog2(MAX_SETS + 1);
  localparam int unsigned UW = UNIVERSE_BITS;
  localparam int unsigned NW = $clog2(UNIVERSE_BITS + 1);
  localparam int unsigned PW = CostW + NW;

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_SCAN, S_COMMIT, S_ERD, S_ELOAD, S_OUT
  } state_e;

  state_e state_q;

  logic [CfgDataW-1:0] max_paths_q, universe_q;
  logic [CW-1:0]       count_q, issue_q;
  logic [UW-1:0]       unc_q;
  logic [ChosenCntW-1:0] chosen_q, emit_k_q;
  logic [TotalW-1:0]   total_q;

  // scan pipe
  logic          p1_v_q, p2_v_q;
  logic [IW-1:0] idx1_q, idx2_q;
  logic [UW-1:0] m1_q, m2_q;
  logic [CostW-1:0] c1_q, c2_q;
  logic [NW-1:0] nw2_q;

  logic [IW-1:0]    best_idx_q;
  logic [NW-1:0]    best_new_q;
  logic [CostW-1:0] best_cost_q;
  logic [UW-1:0]    best_mask_q;

  logic [UW-1:0]    masks_mem [MAX_SETS];
  logic [CostW-1:0] costs_mem [MAX_SETS];
  logic [IdxOutW+TotalW-1:0] chosen_mem [ChosenDepth];
  logic [IdxOutW+TotalW-1:0] emit_q;

  logic               out_valid_q, out_status_q, out_last_q;
  logic [IdxOutW-1:0] out_idx_q;
  logic [TotalW-1:0]  out_total_q;

  logic in_acc, load_we, rd_en, chosen_we;
  logic [IW-1:0] rd_addr;
  logic [CfgDataW-1:0] usize;
  logic [UW-1:0] umask;
  logic [NW-1:0] nw1;
  logic [PW-1:0] lhs, rhs;
  logic better;
  logic [TotalW-1:0] total_nx;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc  = in_i.valid && in_i.ready;
  assign load_we = in_acc && (in_i.mode == ModeLoad) && (count_q < CW'(MAX_SETS));

  assign out_o.valid      = out_valid_q;
  assign out_o.set_index  = out_idx_q;
  assign out_o.run_total  = out_total_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

  always_comb begin
    usize = universe_q;
    if (usize == '0) usize = 7'd1;
    if (usize > CfgDataW'(UNIVERSE_BITS)) usize = CfgDataW'(UNIVERSE_BITS);
    for (int b = 0; b < UW; b++) umask[b] = (CfgDataW'(b) < usize);
  end

  assign rd_en   = (state_q == S_SCAN) && (issue_q < count_q);
  assign rd_addr = issue_q[IW-1:0];
  assign nw1     = NW'($countones(m1_q & unc_q));

  assign lhs = PW'(c2_q) * PW'(best_new_q);
  assign rhs = PW'(best_cost_q) * PW'(nw2_q);
  always_comb begin
    if (idx2_q == '0)          better = 1'b1;
    else if (nw2_q == '0)      better = 1'b0;
    else if (best_new_q == '0) better = 1'b1;
    else                       better = lhs < rhs;
  end

  assign chosen_we = (state_q == S_COMMIT) && (best_new_q != '0);
  assign total_nx  = total_q + TotalW'(best_cost_q);

  // set store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      masks_mem[count_q[IW-1:0]] <= in_i.set_mask[UW-1:0];
      costs_mem[count_q[IW-1:0]] <= in_i.cost;
    end
    if (rd_en) begin
      m1_q <= masks_mem[rd_addr];
      c1_q <= costs_mem[rd_addr];
    end
    m2_q  <= m1_q;
    c2_q  <= c1_q;
    nw2_q <= nw1;
  end

  always_ff @(posedge clk_i) begin
    if (chosen_we) chosen_mem[chosen_q[IdxOutW-1:0]] <= {IdxOutW'(best_idx_q), total_nx};
    if (state_q == S_ERD) emit_q <= chosen_mem[emit_k_q[IdxOutW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_paths_q <= MaxPathsRst;
      universe_q  <= UniverseRst;
      count_q     <= '0;
      issue_q     <= '0;
      unc_q       <= '0;
      chosen_q    <= '0;
      emit_k_q    <= '0;
      total_q     <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      idx1_q      <= '0;
      idx2_q      <= '0;
      best_idx_q  <= '0;
      best_new_q  <= '0;
      best_cost_q <= '0;
      best_mask_q <= '0;
      out_valid_q <= 1'b0;
      out_status_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_total_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == CfgMaxPaths) max_paths_q <= cfg_i.data;
        if (cfg_i.index == CfgUniverse) universe_q  <= cfg_i.data;
      end
      p1_v_q <= rd_en;
      idx1_q <= rd_addr;
      p2_v_q <= p1_v_q;
      idx2_q <= idx1_q;
      if (rd_en) issue_q <= issue_q + 1'b1;
      if (p2_v_q && better) begin
        best_idx_q  <= idx2_q;
        best_new_q  <= nw2_q;
        best_cost_q <= c2_q;
        best_mask_q <= m2_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.mode == ModeClear) count_q <= '0;
            if (load_we) count_q <= count_q + 1'b1;
            if (in_i.mode == ModeRun) begin
              if (count_q == '0) begin
                out_idx_q    <= '0;
                out_total_q  <= '0;
                out_status_q <= 1'b1;
                out_last_q   <= 1'b1;
                out_valid_q  <= 1'b1;
                state_q      <= S_OUT;
              end else begin
                unc_q    <= umask;
                chosen_q <= '0;
                total_q  <= '0;
                state_q  <= S_ROUND;
              end
            end
          end
        end
        S_ROUND: begin
          if (unc_q == '0) begin
            emit_k_q <= '0;
            state_q  <= S_ERD;
          end else if (chosen_q >= max_paths_q ||
                       chosen_q >= ChosenCntW'(ChosenDepth)) begin
            out_idx_q    <= '0;
            out_total_q  <= '0;
            out_status_q <= 1'b1;
            out_last_q   <= 1'b1;
            out_valid_q  <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            issue_q <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!rd_en && !p1_v_q && !p2_v_q) state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (best_new_q == '0) begin
            out_idx_q    <= '0;
            out_total_q  <= '0;
            out_status_q <= 1'b1;
            out_last_q   <= 1'b1;
            out_valid_q  <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            unc_q    <= unc_q & ~best_mask_q;
            total_q  <= total_nx;
            chosen_q <= chosen_q + 1'b1;
            state_q  <= S_ROUND;
          end
        end
        S_ERD: state_q <= S_ELOAD;
        S_ELOAD: begin
          out_idx_q    <= emit_q[IdxOutW+TotalW-1:TotalW];
          out_total_q  <= emit_q[TotalW-1:0];
          out_status_q <= 1'b0;
          out_last_q   <= (emit_k_q + 1'b1 == chosen_q);
          out_valid_q  <= 1'b1;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= S_IDLE;
            end else begin
              emit_k_q <= emit_k_q + 1'b1;
              state_q  <= S_ERD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |-> (CW'(idx2_q) < count_q))
    else $error("scan pipe index beyond loaded sets");

  a_commit_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chosen_we |=> ((unc_q & $past(best_mask_q)) == '0))
    else $error("chosen set left requests uncovered");

  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_last_q && out_total_q == '0))
    else $error("failure request not final");

  a_chosen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chosen_q <= ChosenCntW'(ChosenDepth))
    else $error("chosen count overflow");

endmodule
`default_nettype wire

[sim/greedy_weighted_set_cover_test.sv]
// Testbench for greedy_weighted_set_cover: directed and random command requests,
// a scoreboard class that predicts every cover result and checks it on arrival.
// Depends on gwsc_pkg, gwsc_if.sv and the block itself.
`default_nettype none
module greedy_weighted_set_cover_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gwsc_pkg::*;

  localparam int unsigned LIMIT   = 10000000;
  localparam int unsigned SETTLE  = 40;

  typedef struct packed {
    logic [IdxOutW-1:0] set_index;
    logic [TotalW-1:0]  run_total;
    logic               status;
    logic               last;
  } cover_entry_t;

  class cover_scoreboard;
    logic [MaskW-1:0] masks [MaxSetsDef];
    logic [CostW-1:0] costs [MaxSetsDef];
    int unsigned      loaded;
    logic [6:0]       path_limit;
    logic [6:0]       universe;
    cover_entry_t     pending [$];
    int unsigned      errors;
    int unsigned      seen;
    int unsigned      fails_seen;

    function new();
      loaded = 0;
      path_limit = MaxPathsRst;
      universe = UniverseRst;
      errors = 0;
      seen = 0;
      fails_seen = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgMaxPaths) path_limit = val;
      else if (idx == CfgUniverse) universe = val;
    endfunction

    function void push_failure();
      cover_entry_t e;
      e = '0;
      e.status = 1'b1;
      e.last = 1'b1;
      pending = {pending, e};
    endfunction

    function void note_request(logic [ModeW-1:0] mode, logic [MaskW-1:0] mask,
                               logic [CostW-1:0] cost);
      logic [MaskW-1:0] open;
      int unsigned      n, best, best_new, nw, picks;
      logic [63:0]      best_cost;
      logic             better;
      int unsigned      chosen [$];
      logic [TotalW-1:0] total;
      cover_entry_t     e;
      if (mode == ModeClear) begin
        loaded = 0;
      end else if (mode == ModeLoad) begin
        if (loaded < MaxSetsDef) begin
          masks[loaded] = mask;
          costs[loaded] = cost;
          loaded++;
        end
      end else if (mode == ModeRun) begin
        if (loaded == 0) begin
          push_failure();
          return;
        end
        n = (universe < 1) ? 1 : (universe > 64) ? 64 : universe;
        open = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
        picks = 0;
        while (open != '0) begin
          if (picks >= path_limit || picks >= ChosenDepth) begin
            push_failure();
            return;
          end
          best = 0; best_new = 0; best_cost = 0;
          for (int i = 0; i < loaded; i++) begin
            nw = $countones(masks[i] & open);
            if (i == 0) better = 1'b1;
            else if (nw == 0) better = 1'b0;
            else if (best_new == 0) better = 1'b1;
            else better = (64'(costs[i]) * 64'(best_new)) < (best_cost * 64'(nw));
            if (better) begin
              best = i; best_new = nw; best_cost = 64'(costs[i]);
            end
          end
          if (best_new == 0) begin
            push_failure();
            return;
          end
          open &= ~masks[best];
          chosen = {chosen, best};
          picks++;
        end
        total = '0;
        foreach (chosen[k]) begin
          total += TotalW'(costs[chosen[k]]);
          e.set_index = chosen[k][IdxOutW-1:0];
          e.run_total = total;
          e.status = 1'b0;
          e.last = (k == chosen.size() - 1);
          pending = {pending, e};
        end
      end
    endfunction

    task check_result(cover_entry_t got);
      cover_entry_t want;
      seen++;
      if (got.status) fails_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result idx %0d status %0d", got.set_index, got.status));
        return;
      end
      want = pending.pop_front();
      if (got.set_index != want.set_index)
        report($sformatf("set_index %0d, want %0d", got.set_index, want.set_index));
      if (got.run_total != want.run_total)
        report($sformatf("run_total %0d, want %0d", got.run_total, want.run_total));
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last != want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  gwsc_in_if  cmd_ch ();
  gwsc_out_if res_ch ();
  gwsc_cfg_if reg_ch ();

  greedy_weighted_set_cover uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source),
    .cfg_i  (reg_ch.sink)
  );

  cover_scoreboard sb;
  bit          idle_on;
  bit          hold_req;
  int unsigned cycles;
  int unsigned requests;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = ModeClear;
    cmd_ch.set_mask = '0;
    cmd_ch.cost = '0;
    reg_ch.valid = 1'b0;
    reg_ch.index = '0;
    reg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, and one long hold-off once asked for
  initial begin
    int unsigned held;
    held = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && held < 400) begin
        res_ch.ready = 1'b0;
        held++;
      end else begin
        res_ch.ready = !(idle_on && $urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk_i) begin
    cover_entry_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.set_index = res_ch.set_index;
      got.run_total = res_ch.run_total;
      got.status = res_ch.status;
      got.last = res_ch.last;
      sb.check_result(got);
    end
  end

  task send_cmd(logic [ModeW-1:0] mode, logic [MaskW-1:0] mask, logic [CostW-1:0] cost);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 30) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.mode = mode;
    cmd_ch.set_mask = mask;
    cmd_ch.cost = cost;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_request(mode, mask, cost);
    requests++;
  endtask

  task drain();
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    reg_ch.valid = 1'b1;
    reg_ch.index = idx;
    reg_ch.data = val;
    do @(posedge clk_i); while (!reg_ch.ready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    reg_ch.valid = 1'b0;
  endtask

  function automatic logic [MaskW-1:0] rand_mask();
    logic [MaskW-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(3))
      0: m &= {$urandom, $urandom};
      1: m |= {$urandom, $urandom};
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [CostW-1:0] rand_cost();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // clear, a few loads, run; now and then a broken or noisy sequence
  task cover_sequence(int unsigned nsets);
    int unsigned r;
    r = $urandom_range(9);
    if (r != 0) send_cmd(ModeClear, rand_mask(), rand_cost());
    if (r == 1) send_cmd(ModeSpare, rand_mask(), rand_cost());
    for (int i = 0; i < nsets; i++) send_cmd(ModeLoad, rand_mask(), rand_cost());
    if (r != 2) send_cmd(ModeRun, rand_mask(), rand_cost());
  endtask

  task random_phase(int unsigned items);
    int unsigned start;
    start = requests;
    while (requests - start < items) cover_sequence($urandom_range(1, 6));
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    hold_req = 1'b0;
    requests = 0;
    @(posedge rst_ni);

    // directed: empty run, unused mode, extremes, ties, limits
    send_cmd(ModeRun, '0, '0);
    send_cmd(ModeSpare, '1, '1);
    send_cmd(ModeLoad, '1, '0);
    send_cmd(ModeLoad, '0, '1);
    send_cmd(ModeRun, '0, '0);
    send_cmd(ModeClear, '0, '0);
    send_cmd(ModeLoad, 64'h0000_0000_FFFF_FFFF, 32'd10);
    send_cmd(ModeLoad, 64'hFFFF_FFFF_0000_0000, 32'd10);
    send_cmd(ModeLoad, 64'h0000_0000_FFFF_FFFF, 32'd10);
    send_cmd(ModeRun, '0, '0);
    send_cmd(ModeClear, '0, '0);
    send_cmd(ModeLoad, 64'h0F, 32'd3);
    send_cmd(ModeRun, '0, '0);
    drain();
    write_reg(CfgMaxPaths, 7'd1);
    write_reg(CfgUniverse, 7'd0);
    send_cmd(ModeRun, '0, '0);
    send_cmd(ModeLoad, 64'h8000_0000_0000_0000, '1);
    send_cmd(ModeRun, '0, '0);
    drain();
    write_reg(CfgUniverse, 7'd127);
    send_cmd(ModeRun, '0, '0);
    drain();
    write_reg(CfgMaxPaths, 7'd0);
    write_reg(CfgUniverse, 7'd4);
    send_cmd(ModeRun, '0, '0);
    drain();

    write_reg(CfgMaxPaths, 7'd64);
    write_reg(CfgUniverse, 7'd8);
    random_phase(25);
    drain();

    // long hold-off on results while runs keep arriving
    hold_req = 1'b1;
    random_phase(10);
    drain();
    hold_req = 1'b0;

    write_reg(CfgMaxPaths, 7'd2);
    write_reg(CfgUniverse, 7'd16);
    idle_on = 1'b0;
    random_phase(25);
    drain();
    idle_on = 1'b1;

    // fill the store past its depth, then run over all entries
    write_reg(CfgMaxPaths, 7'd127);
    write_reg(CfgUniverse, 7'd64);
    send_cmd(ModeClear, '0, '0);
    for (int i = 0; i < 66; i++) send_cmd(ModeLoad, rand_mask(), rand_cost());
    send_cmd(ModeRun, '0, '0);
    drain();

    write_reg(CfgMaxPaths, 7'd3);
    write_reg(CfgUniverse, 7'd1);
    random_phase(10);
    drain();
    write_reg(CfgMaxPaths, 7'd64);
    write_reg(CfgUniverse, 7'd32);
    random_phase(10);
    drain();

    $display("covered %0d command requests, %0d results (%0d failure results)",
             requests, sb.seen, sb.fails_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[greedy_weighted_set_cover.f]
hdl/gwsc_pkg.sv
hdl/gwsc_if.sv
hdl/greedy_weighted_set_cover.sv
sim/greedy_weighted_set_cover_test.sv
